>>> sv/mimq_pkg.sv
// Package for the middle-insert queue: transfer payload types and operation codes.
// Used by mimq_ctrl and middle_insert_queue_unit; no dependencies of its own.
package mimq_pkg;

    localparam int OCC_W   = 11;
    localparam int VALUE_W = 32;

    localparam logic [1:0] ACT_PUSH_TAIL = 2'd0;
    localparam logic [1:0] ACT_PUSH_MID  = 2'd1;
    localparam logic [1:0] ACT_POP       = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] popped_value;
        logic [OCC_W-1:0]          occupancy;
    } t_out_item;

endpackage

>>> sv/middle_insert_queue_unit.sv
// Middle-insert queue top level: input register, queue control, two half rings, result register.
// Input and result are both registered; one item per cycle sustained unless the output stalls.
// Throughput is set by the registered head reads of the two rings, refreshed every cycle.
// Reset (i_rst_n low, synchronous) empties the queue and drops any held item or result.
// Ring contents are not cleared; no clearing pass is needed after reset.
module middle_insert_queue_unit #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mimq_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mimq_pkg::t_out_item  o_out_item
);
    import mimq_pkg::*;

    localparam int HALF_CAP = (DEPTH + 1) / 2;
    localparam int PW       = (HALF_CAP > 1) ? $clog2(HALF_CAP) : 1;
    localparam int SW       = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    t_out_item result;

    logic          front_we, back_we;
    logic [PW-1:0] front_waddr, front_raddr, back_waddr, back_raddr;
    logic [SW-1:0] front_wdata, back_wdata, front_rdata, back_rdata;

    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    mimq_ctrl #(
        .DEPTH    (DEPTH),
        .HALF_CAP (HALF_CAP),
        .PW       (PW),
        .SW       (SW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_go              (advance),
        .i_item            (r_in_item),
        .i_front_head_word (front_rdata),
        .i_back_head_word  (back_rdata),
        .o_front_we        (front_we),
        .o_front_waddr     (front_waddr),
        .o_front_wdata     (front_wdata),
        .o_front_raddr     (front_raddr),
        .o_back_we         (back_we),
        .o_back_waddr      (back_waddr),
        .o_back_wdata      (back_wdata),
        .o_back_raddr      (back_raddr),
        .o_result          (result)
    );

    mimq_ram #(
        .ENTRIES (HALF_CAP),
        .WIDTH   (SW),
        .AW      (PW)
    ) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (front_we),
        .i_waddr (front_waddr),
        .i_wdata (front_wdata),
        .i_raddr (front_raddr),
        .o_rdata (front_rdata)
    );

    mimq_ram #(
        .ENTRIES (HALF_CAP),
        .WIDTH   (SW),
        .AW      (PW)
    ) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (back_we),
        .i_waddr (back_waddr),
        .i_wdata (back_wdata),
        .i_raddr (back_raddr),
        .o_rdata (back_rdata)
    );

    // hold the result while stalled, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> sv/mimq_ram.sv
// Ring storage for one half of the queue: one write port, one registered read port.
// A read at the address being written returns the new word. No dependencies.
module mimq_ram #(
    parameter int ENTRIES = 512,
    parameter int WIDTH   = 32,
    parameter int AW      = 9
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // forward the word written in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/mimq_ctrl.sv
// Queue control: ring pointers and counts of both halves, operation decode, rebalance.
// Depends on mimq_pkg; drives the write and read ports of the two mimq_ram instances.
module mimq_ctrl #(
    parameter int DEPTH    = 1024,
    parameter int HALF_CAP = 512,
    parameter int PW       = 9,
    parameter int SW       = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  mimq_pkg::t_in_item   i_item,
    input  logic [SW-1:0]        i_front_head_word,
    input  logic [SW-1:0]        i_back_head_word,
    output logic                 o_front_we,
    output logic [PW-1:0]        o_front_waddr,
    output logic [SW-1:0]        o_front_wdata,
    output logic [PW-1:0]        o_front_raddr,
    output logic                 o_back_we,
    output logic [PW-1:0]        o_back_waddr,
    output logic [SW-1:0]        o_back_wdata,
    output logic [PW-1:0]        o_back_raddr,
    output mimq_pkg::t_out_item  o_result
);
    import mimq_pkg::*;

    localparam int CW   = $clog2(HALF_CAP + 1);
    localparam int SUMW = CW + 1;
    localparam int SZW  = $clog2(DEPTH + 1);
    localparam int OXW  = SZW + OCC_W;
    localparam logic [PW-1:0] LAST = PW'(HALF_CAP - 1);

    logic [PW-1:0] r_fh, n_fh, r_bh, n_bh;
    logic [CW-1:0] r_fc, n_fc, r_bc, n_bc;

    logic [SUMW-1:0] f_sum, b_sum;
    logic [PW-1:0]   f_tail, b_tail, fh_inc, bh_inc, bh_dec;
    logic [SZW-1:0]  size, n_size;
    logic [OXW-1:0]  occ_ext;
    logic            full, f_we, b_we;
    logic [PW-1:0]   b_wa;
    logic [SW-1:0]   f_wd, word;
    logic [1:0]      status;
    logic [SW-1:0]   popped;

    always_comb begin
        f_sum  = SUMW'(r_fh) + SUMW'(r_fc);
        b_sum  = SUMW'(r_bh) + SUMW'(r_bc);
        f_tail = (f_sum >= SUMW'(HALF_CAP)) ? PW'(f_sum - SUMW'(HALF_CAP)) : PW'(f_sum);
        b_tail = (b_sum >= SUMW'(HALF_CAP)) ? PW'(b_sum - SUMW'(HALF_CAP)) : PW'(b_sum);
        fh_inc = (r_fh == LAST) ? '0 : r_fh + PW'(1);
        bh_inc = (r_bh == LAST) ? '0 : r_bh + PW'(1);
        bh_dec = (r_bh == '0) ? LAST : r_bh - PW'(1);
        size   = SZW'(r_fc) + SZW'(r_bc);
        full   = (size >= SZW'(DEPTH));
        word   = i_item.value[SW-1:0];

        n_fh   = r_fh;
        n_bh   = r_bh;
        n_fc   = r_fc;
        n_bc   = r_bc;
        f_we   = 1'b0;
        b_we   = 1'b0;
        f_wd   = word;
        b_wa   = b_tail;
        status = ST_OK;
        popped = '0;

        case (i_item.action)
            ACT_PUSH_TAIL: begin
                if (full) begin
                    status = ST_FULL;
                end else if (size[0]) begin
                    b_we = 1'b1;
                    n_bc = r_bc + CW'(1);
                end else if (r_bc == '0) begin
                    f_we = 1'b1;
                    n_fc = r_fc + CW'(1);
                end else begin
                    // append to back, move back head to front tail
                    b_we = 1'b1;
                    f_we = 1'b1;
                    f_wd = i_back_head_word;
                    n_bh = bh_inc;
                    n_fc = r_fc + CW'(1);
                end
            end
            ACT_PUSH_MID: begin
                if (full) begin
                    status = ST_FULL;
                end else if (!size[0]) begin
                    f_we = 1'b1;
                    n_fc = r_fc + CW'(1);
                end else begin
                    b_we = 1'b1;
                    b_wa = bh_dec;
                    n_bh = bh_dec;
                    n_bc = r_bc + CW'(1);
                end
            end
            ACT_POP: begin
                if (size == '0) begin
                    status = ST_EMPTY;
                end else begin
                    popped = i_front_head_word;
                    n_fh   = fh_inc;
                    n_fc   = r_fc - CW'(1);
                    if (!size[0] && (r_bc != '0)) begin
                        // refill front tail from back head
                        f_we = 1'b1;
                        f_wd = i_back_head_word;
                        n_bh = bh_inc;
                        n_bc = r_bc - CW'(1);
                        n_fc = r_fc;
                    end
                end
            end
            default: begin
            end
        endcase

        n_size  = SZW'(n_fc) + SZW'(n_bc);
        occ_ext = OXW'(n_size);
    end

    assign o_front_we    = i_go & f_we;
    assign o_front_waddr = f_tail;
    assign o_front_wdata = f_wd;
    assign o_front_raddr = i_go ? n_fh : r_fh;
    assign o_back_we     = i_go & b_we;
    assign o_back_waddr  = b_wa;
    assign o_back_wdata  = word;
    assign o_back_raddr  = i_go ? n_bh : r_bh;

    assign o_result.status       = status;
    assign o_result.popped_value = VALUE_W'(popped);
    assign o_result.occupancy    = occ_ext[OCC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fh <= '0;
            r_bh <= '0;
            r_fc <= '0;
            r_bc <= '0;
        end else if (i_go) begin
            r_fh <= n_fh;
            r_bh <= n_bh;
            r_fc <= n_fc;
            r_bc <= n_bc;
        end
    end

endmodule
